### src/vp9tlv_pkg.sv
// Types and constants shared by the VP9 feature record parser.
// No dependencies; used by vp9tlv_step, vp9tlv_out_reg and the top level.
package vp9tlv_pkg;

    localparam logic [7:0] FEATURE_PROFILE           = 8'd1;
    localparam logic [7:0] FEATURE_LEVEL             = 8'd2;
    localparam logic [7:0] FEATURE_BIT_DEPTH         = 8'd3;
    localparam logic [7:0] FEATURE_CHROMA_SUBSAMPLING = 8'd4;

    localparam int NUM_FIELDS = 4;
    localparam int OUT_BITS   = 37;
    localparam int OUT_BYTES  = (OUT_BITS + 7) / 8;
    localparam int OUT_WIDTH  = OUT_BYTES * 8;

    typedef enum logic [3:0] {
        PH_ID    = 4'b0001,
        PH_SIZE  = 4'b0010,
        PH_VALUE = 4'b0100,
        PH_SKIP  = 4'b1000
    } phase_t;

    // Per-record parse state, cleared at the end of every record
    typedef struct packed {
        phase_t     phase;
        logic [7:0] entry_id;
        logic [7:0] bytes_to_skip;
        logic       failed;
    } parse_state_t;

    // Stored features, kept across records until reset
    typedef struct packed {
        logic [NUM_FIELDS-1:0][7:0] values;
        logic [NUM_FIELDS-1:0]      present;
    } fields_t;

    typedef struct packed {
        logic    status;
        fields_t fields;
    } result_t;

    localparam parse_state_t STATE_CLEAR = '{
        phase:         PH_ID,
        entry_id:      8'd0,
        bytes_to_skip: 8'd0,
        failed:        1'b0
    };

endpackage

### src/vp9tlv_step.sv
// Next-state logic of the feature record parser for one record byte.
// Depends on vp9tlv_pkg for the state, field and result types.
module vp9tlv_step (
    input  vp9tlv_pkg::parse_state_t state_cur,
    input  vp9tlv_pkg::fields_t      fields_cur,
    input  logic [7:0]               record_byte,
    input  logic                     last_byte,
    output vp9tlv_pkg::parse_state_t state_next,
    output vp9tlv_pkg::fields_t      fields_next,
    output vp9tlv_pkg::result_t      result
);

    vp9tlv_pkg::parse_state_t upd;
    logic                     known;
    logic [1:0]               field_idx;
    logic [7:0]               skip_dec;

    assign known = (state_cur.entry_id >= vp9tlv_pkg::FEATURE_PROFILE) &&
                   (state_cur.entry_id <= vp9tlv_pkg::FEATURE_CHROMA_SUBSAMPLING);
    assign field_idx = state_cur.entry_id[1:0] - 2'd1;
    assign skip_dec  = state_cur.bytes_to_skip - 8'd1;

    always_comb begin
        upd         = state_cur;
        fields_next = fields_cur;
        if (!state_cur.failed) begin
            case (state_cur.phase)
                vp9tlv_pkg::PH_ID: begin
                    upd.entry_id = record_byte;
                    upd.phase    = vp9tlv_pkg::PH_SIZE;
                end
                vp9tlv_pkg::PH_SIZE: begin
                    if (known) begin
                        if (record_byte != 8'd1) begin
                            upd.failed = 1'b1;
                        end else begin
                            upd.phase = vp9tlv_pkg::PH_VALUE;
                        end
                    end else begin
                        upd.bytes_to_skip = record_byte;
                        upd.phase = (record_byte == 8'd0) ? vp9tlv_pkg::PH_ID
                                                          : vp9tlv_pkg::PH_SKIP;
                    end
                end
                vp9tlv_pkg::PH_VALUE: begin
                    fields_next.values[field_idx]  = record_byte;
                    fields_next.present[field_idx] = 1'b1;
                    upd.phase = vp9tlv_pkg::PH_ID;
                end
                vp9tlv_pkg::PH_SKIP: begin
                    upd.bytes_to_skip = skip_dec;
                    if (skip_dec == 8'd0) begin
                        upd.phase = vp9tlv_pkg::PH_ID;
                    end
                end
                default: begin
                    upd = state_cur;
                end
            endcase
        end
    end

    // Status sees the state after this byte; a last byte starts a fresh record
    assign result.status = upd.failed || (upd.phase != vp9tlv_pkg::PH_ID);
    assign result.fields = fields_next;
    assign state_next    = last_byte ? vp9tlv_pkg::STATE_CLEAR : upd;

endmodule

### src/vp9tlv_out_reg.sv
// Result register of the parser: holds one packed result beat until taken.
// Depends on vp9tlv_pkg for the result type and the output width.
module vp9tlv_out_reg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               load,
    input  vp9tlv_pkg::result_t                result,
    output logic                               slot_free,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [vp9tlv_pkg::OUT_WIDTH-1:0]   m_tdata
);

    logic                                 valid_reg;
    logic                                 valid_next;
    logic [vp9tlv_pkg::OUT_WIDTH-1:0]     data_reg;
    logic [vp9tlv_pkg::OUT_BITS-1:0]      packed_res;

    // Pack from the lowest bit: status, then value and present flag per field
    always_comb begin
        packed_res[0] = result.status;
        for (int i = 0; i < vp9tlv_pkg::NUM_FIELDS; i++) begin
            packed_res[1 + 9*i +: 8] = result.fields.values[i];
            packed_res[9 + 9*i]      = result.fields.present[i];
        end
    end

    assign slot_free  = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {{(vp9tlv_pkg::OUT_WIDTH - vp9tlv_pkg::OUT_BITS){1'b0}}, packed_res};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

### src/vp9_codec_feature_tlv_parser_core.sv
// Top level of the VP9 codec-private feature record parser.
// Depends on vp9tlv_pkg, vp9tlv_step and vp9tlv_out_reg.
//
//  channel  | direction | ports                        | payload
//  ---------+-----------+------------------------------+------------------------------
//  s_       | in        | s_tvalid s_tready s_tdata    | record_byte in tdata, last_byte
//           |           | s_tlast                      | as tlast
//  m_       | out       | m_tvalid m_tready m_tdata    | status and the four stored
//           |           |                              | features, one beat per record
//
// Cycles: one record byte per cycle while no last byte waits for the result register.
// A byte lands in the input register and is parsed by the step logic from there; if
// it is the last byte, its result beat goes into the result register and out on m_.
// Reset: aresetn, synchronous active low, clears the parse state, the stored
// features and both valid flags. Stalls: only a last byte waits for the result
// register; other bytes advance while a result beat is still pending on m_.
module vp9_codec_feature_tlv_parser_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] record_byte
    input  logic                             s_tlast,   // last_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] status, [8:1] profile_value, [9] profile_present, [17:10] level_value,
    // [18] level_present, [26:19] depth_value, [27] depth_present,
    // [35:28] subsampling_value, [36] subsampling_present, [39:37] zero
    output logic [vp9tlv_pkg::OUT_WIDTH-1:0] m_tdata
);

    // Input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Parser state
    vp9tlv_pkg::parse_state_t state_reg;
    vp9tlv_pkg::parse_state_t state_next;
    vp9tlv_pkg::fields_t      fields_reg;
    vp9tlv_pkg::fields_t      fields_next;
    vp9tlv_pkg::result_t      result;

    logic slot_free;
    logic fire;
    logic s_beat;

    // Advance the held byte unless it is a last byte and the result slot is busy
    assign fire     = in_valid_reg && (!in_last_reg || slot_free);
    assign s_tready = !in_valid_reg || fire;
    assign s_beat   = s_tvalid && s_tready;

    assign in_valid_next = s_beat || (in_valid_reg && !fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    vp9tlv_step u_step (
        .state_cur   (state_reg),
        .fields_cur  (fields_reg),
        .record_byte (in_byte_reg),
        .last_byte   (in_last_reg),
        .state_next  (state_next),
        .fields_next (fields_next),
        .result      (result)
    );

    // Commit parse state and stored features only when the byte is consumed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= vp9tlv_pkg::STATE_CLEAR;
            fields_reg <= '0;
        end else if (fire) begin
            state_reg  <= state_next;
            fields_reg <= fields_next;
        end
    end

    vp9tlv_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (fire && in_last_reg),
        .result    (result),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### dv/tb.sv
// Testbench for vp9_codec_feature_tlv_parser_core: feeds feature records byte by byte
// and checks every result beat against a tracker of the parse state and stored features.
// Depends on vp9tlv_pkg and the parser RTL only.
`timescale 1ns / 100ps

module tb;

    localparam int ITEMS       = 1300;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    // Tracks what the parser should have seen so far and queues the report that every
    // record-ending beat is due to produce. Stored features persist across records.
    class feature_tracker;
        vp9tlv_pkg::phase_t  phase;
        logic [7:0]          entry_id;
        logic [7:0]          skip_left;
        bit                  failed;
        logic [3:0][7:0]     value;
        logic [3:0]          present;
        vp9tlv_pkg::result_t due_reports[$];
        int                  mismatches;
        int                  records;
        int                  bad_records;

        function new();
            value       = '0;
            present     = '0;
            mismatches  = 0;
            records     = 0;
            bad_records = 0;
            clear_record();
        endfunction

        function void clear_record();
            phase     = vp9tlv_pkg::PH_ID;
            entry_id  = 8'd0;
            skip_left = 8'd0;
            failed    = 1'b0;
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        // Advance the parse state by one accepted byte; queue a report on the last one.
        function void take_byte(logic [7:0] b, logic last);
            vp9tlv_pkg::result_t rep;
            logic [1:0]          k;
            if (!failed) begin
                case (phase)
                    vp9tlv_pkg::PH_ID: begin
                        entry_id = b;
                        phase    = vp9tlv_pkg::PH_SIZE;
                    end
                    vp9tlv_pkg::PH_SIZE: begin
                        if (entry_id >= vp9tlv_pkg::FEATURE_PROFILE &&
                            entry_id <= vp9tlv_pkg::FEATURE_CHROMA_SUBSAMPLING) begin
                            if (b != 8'd1)
                                failed = 1'b1;
                            else
                                phase = vp9tlv_pkg::PH_VALUE;
                        end else begin
                            skip_left = b;
                            phase     = (b == 8'd0) ? vp9tlv_pkg::PH_ID
                                                    : vp9tlv_pkg::PH_SKIP;
                        end
                    end
                    vp9tlv_pkg::PH_VALUE: begin
                        k          = 2'(entry_id - 8'd1);
                        value[k]   = b;
                        present[k] = 1'b1;
                        phase      = vp9tlv_pkg::PH_ID;
                    end
                    default: begin
                        skip_left = skip_left - 8'd1;
                        if (skip_left == 8'd0)
                            phase = vp9tlv_pkg::PH_ID;
                    end
                endcase
            end
            if (last) begin
                rep.status         = failed || (phase != vp9tlv_pkg::PH_ID);
                rep.fields.values  = value;
                rep.fields.present = present;
                due_reports.push_back(rep);
                records++;
                if (rep.status)
                    bad_records++;
                clear_record();
            end
        endfunction

        function void fault(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: MISMATCH %s", $realtime, msg);
        endfunction

        // Compare one result beat with the oldest report still due, field by field.
        function void check_report(logic [vp9tlv_pkg::OUT_WIDTH-1:0] d);
            vp9tlv_pkg::result_t exp;
            logic [7:0]          got_value;
            logic                got_present;
            string               names[4];
            names = '{"profile", "level", "bit depth", "subsampling"};
            if (due_reports.size() == 0) begin
                fault($sformatf("result beat %h with no record outstanding", d));
                return;
            end
            exp = due_reports.pop_front();
            if (d[0] !== exp.status)
                fault($sformatf("status expected %0b got %0b", exp.status, d[0]));
            for (int k = 0; k < vp9tlv_pkg::NUM_FIELDS; k++) begin
                got_value   = d[1 + 9*k +: 8];
                got_present = d[9 + 9*k];
                if (got_value !== exp.fields.values[k])
                    fault($sformatf("%s value expected %h got %h", names[k],
                                    exp.fields.values[k], got_value));
                if (got_present !== exp.fields.present[k])
                    fault($sformatf("%s present expected %0b got %0b", names[k],
                                    exp.fields.present[k], got_present));
            end
        endfunction
    endclass

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [7:0]                       s_tdata;    // [7:0] record_byte
    logic                             s_tlast;    // last_byte
    logic                             m_tvalid;
    logic                             m_tready;
    // [0] status, then per feature an 8-bit value and a present flag, [39:37] zero
    logic [vp9tlv_pkg::OUT_WIDTH-1:0] m_tdata;

    feature_tracker tracker;
    logic [7:0]     rec[$];
    int             burst_left;
    int             sent_bytes;
    bit             hold_req;

    vp9_codec_feature_tlv_parser_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Sample both channels on the edge; all drivers use nonblocking updates, so the
    // values read here are the ones the block saw at this edge.
    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (s_tvalid && s_tready)
                tracker.take_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                tracker.check_report(m_tdata);
        end
    end

    // Receiver: rotate a stall pattern that is reloaded when its countdown runs out, sometimes
    // all-ready, sometimes sparse. On request hold off for a long counted stretch.
    initial begin
        logic [15:0] stall_bits;
        int          reload_in;
        int          held;
        m_tready   <= 1'b0;
        stall_bits  = 16'hFFFF;
        reload_in   = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                held      = 0;
                m_tready <= 1'b0;
                while (held < HOLD_CYCLES) begin
                    @(posedge aclk);
                    held++;
                end
            end
            if (reload_in == 0) begin
                case ($urandom_range(0, 3))
                    0:       stall_bits = 16'hFFFF;
                    1:       stall_bits = 16'($urandom);
                    2:       stall_bits = 16'($urandom) | 16'($urandom);
                    default: stall_bits = 16'($urandom) & 16'($urandom);
                endcase
                stall_bits[0] = 1'b1;
                reload_in     = 64;
            end
            m_tready  <= stall_bits[0];
            stall_bits = {stall_bits[0], stall_bits[15:1]};
            reload_in--;
        end
    end

    // Offer one byte and hold it until the block takes it. Gaps fall between bursts;
    // tvalid stays high from one beat to the next within a burst.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        sent_bytes++;
    endtask

    task automatic send_record();
        foreach (rec[i])
            send_byte(rec[i], i == rec.size() - 1);
    endtask

    // Drop tvalid and wait until every queued report has been checked.
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Append one well-formed entry: a known feature with a value byte, or an unknown
    // id whose value bytes the block should skip. Sizes are mostly small.
    task automatic add_entry(input bit known);
        logic [7:0] id;
        logic [7:0] len;
        if (known) begin
            rec.push_back(8'($urandom_range(vp9tlv_pkg::FEATURE_PROFILE,
                                            vp9tlv_pkg::FEATURE_CHROMA_SUBSAMPLING)));
            rec.push_back(8'd1);
            rec.push_back(8'($urandom_range(0, 255)));
        end else begin
            do id = 8'($urandom_range(0, 255));
            while (id >= vp9tlv_pkg::FEATURE_PROFILE &&
                   id <= vp9tlv_pkg::FEATURE_CHROMA_SUBSAMPLING);
            len = ($urandom_range(0, 59) == 0) ? 8'($urandom_range(5, 255))
                                               : 8'($urandom_range(0, 4));
            rec.push_back(id);
            rec.push_back(len);
            repeat (len) rec.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Mostly well-formed records; the rest carry a bad size on a known id, are cut
    // short, or are plain noise.
    task automatic make_record();
        int         kind;
        int         cut;
        logic [7:0] bad_size;
        rec.delete();
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            repeat ($urandom_range(1, 5)) add_entry($urandom_range(0, 1));
        end else if (kind == 7) begin
            repeat ($urandom_range(0, 2)) add_entry($urandom_range(0, 1));
            do bad_size = 8'($urandom_range(0, 255));
            while (bad_size == 8'd1);
            rec.push_back(8'($urandom_range(vp9tlv_pkg::FEATURE_PROFILE,
                                            vp9tlv_pkg::FEATURE_CHROMA_SUBSAMPLING)));
            rec.push_back(bad_size);
            repeat ($urandom_range(0, 4)) rec.push_back(8'($urandom_range(0, 255)));
        end else if (kind == 8) begin
            repeat ($urandom_range(1, 4)) add_entry($urandom_range(0, 1));
            cut = $urandom_range(1, rec.size() - 1);
            while (rec.size() > cut) void'(rec.pop_back());
        end else begin
            repeat ($urandom_range(1, 10)) rec.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        bit held_off;
        bit paused;
        s_tvalid   <= 1'b0;
        s_tdata    <= 8'd0;
        s_tlast    <= 1'b0;
        aresetn    <= 1'b0;
        tracker     = new();
        burst_left  = 0;
        sent_bytes  = 0;
        hold_req    = 1'b0;
        held_off    = 1'b0;
        paused      = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // All four features, with the value extremes; record parses cleanly
        rec = '{vp9tlv_pkg::FEATURE_PROFILE, 8'd1, 8'd0,
                vp9tlv_pkg::FEATURE_LEVEL, 8'd1, 8'd255,
                vp9tlv_pkg::FEATURE_BIT_DEPTH, 8'd1, 8'd10,
                vp9tlv_pkg::FEATURE_CHROMA_SUBSAMPLING, 8'd1, 8'd85};
        send_record();
        // Unknown id with size zero: entry complete after its size byte
        rec = '{8'd0, 8'd0};
        send_record();
        // Unknown id: skip its value bytes
        rec = '{8'd255, 8'd2, 8'd170, 8'd85};
        send_record();
        // Known id with wrong size: error, the rest ignored, stored fields kept
        rec = '{vp9tlv_pkg::FEATURE_LEVEL, 8'd0, 8'd1, 8'd7};
        send_record();
        // Record ends right after an id byte
        rec = '{vp9tlv_pkg::FEATURE_BIT_DEPTH};
        send_record();
        // Record ends before the value byte of a known entry
        rec = '{vp9tlv_pkg::FEATURE_CHROMA_SUBSAMPLING, 8'd1};
        send_record();
        // Record ends part-way through skipped value bytes
        rec = '{8'd9, 8'd3, 8'd1};
        send_record();
        drain();

        while (sent_bytes < ITEMS) begin
            // Hold the receiver off and keep sending short records so that the
            // result register fills and the block stalls its input.
            if (!held_off && sent_bytes >= 450) begin
                held_off = 1'b1;
                hold_req = 1'b1;
                repeat (8) begin
                    rec = '{8'd0, 8'd0};
                    send_record();
                end
            end
            if (!paused && sent_bytes >= 900) begin
                paused = 1'b1;
                drain();
            end
            make_record();
            send_record();
        end
        drain();
        repeat (10) @(posedge aclk);

        $display("Fed %0d record bytes over %0d records (%0d malformed or truncated),",
                 sent_bytes, tracker.records, tracker.bad_records);
        $display("with random stalls on both sides and one long receiver hold-off.");
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #2000000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
